/* rtl/core/assert_macros.svh */
// assertion macros used by the wavetable voice sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/wvp_pkg.sv */
// types, constants and helpers for the wavetable voice with pan
`default_nettype none

package wvp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int LEN_W    = 13;
  localparam int LEVEL_W  = 16;
  localparam int WIDX_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = PHASE_W + 1;
  localparam int MUL_B_W = LEVEL_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // q1.15 rounding of a q1.15 * q1.15 * q1.15 product
  localparam int RND_SHIFT = 30;
  localparam logic [PROD_W-1:0] RND_BIAS = PROD_W'(64'd1 << (RND_SHIFT - 1));

  localparam logic [LEVEL_W-1:0] UNITY = 16'd32768;

  // register reset values
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP   = '0;
  localparam logic [LEN_W-1:0]   RST_TABLE_LENGTH = 13'd4096;
  localparam logic [LEVEL_W-1:0] RST_VOLUME       = 16'd32768;
  localparam logic [LEVEL_W-1:0] RST_PAN          = 16'd16384;
  localparam logic [LEVEL_W-1:0] RST_SILENCE      = 16'd33;

  typedef enum logic [0:0] {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_TABLE_LENGTH = 3'd1,
    CFG_VOLUME       = 3'd2,
    CFG_PAN          = 3'd3,
    CFG_SILENCE      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_GAIN,
    ST_LEFT,
    ST_RIGHT,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_e_t                     command;
    logic [WIDX_W-1:0]          table_index;
    logic signed [SAMPLE_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [LEN_W-1:0]   table_length;
    logic [LEVEL_W-1:0] volume;
    logic [LEVEL_W-1:0] pan;
    logic [LEVEL_W-1:0] silence_level;
  } cfg_regs_t;

  // round half up to q1.15 and keep the low sample bits
  function automatic logic signed [SAMPLE_W-1:0] round_q15(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:0] t;
    t = p + RND_BIAS;
    return t[RND_SHIFT+SAMPLE_W-1:RND_SHIFT];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wvp_mul.sv */
// shared signed multiplier with registered product
`default_nettype none

module wvp_mul (
  input  wire logic                                 clk,
  input  wire logic signed [wvp_pkg::MUL_A_W-1:0]   mul_a,
  input  wire logic signed [wvp_pkg::MUL_B_W-1:0]   mul_b,
  output logic signed      [wvp_pkg::PROD_W-1:0]    mul_p
);
  import wvp_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

`default_nettype wire

/* rtl/core/wvp_table.sv */
// wave table memory, one write port and one registered read port
`default_nettype none

module wvp_table #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW          = 12
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [wvp_pkg::SAMPLE_W-1:0]  wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [wvp_pkg::SAMPLE_W-1:0]  rd_data
);
  import wvp_pkg::*;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/wvp_seq.sv */
// sequencer, phase accumulator and output register of the voice
`default_nettype none

module wvp_seq #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wvp_pkg::cfg_regs_t   cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wvp_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wvp_pkg::out_item_t        out_data
);
  import wvp_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_CLAMP =
    LEN_W'((TABLE_DEPTH > LEN_MAX) ? LEN_MAX : TABLE_DEPTH);
  localparam int IDX_LO = PHASE_W;
  localparam int IDX_HI = PHASE_W + LEN_W - 1;
  localparam int SG_W   = MUL_A_W;

  state_t                   state_r, state_nxt;
  logic [PHASE_W-1:0]       phase_r;
  logic signed [SG_W-1:0]   sg_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     out_free;
  logic                     in_fire;
  logic                     is_tick;
  logic                     muted;
  logic                     mute_fire;
  logic                     step_fire;
  logic                     load_out;
  logic [LEN_W-1:0]         len;
  logic [LEVEL_W-1:0]       gain;
  logic [LEVEL_W-1:0]       rshare;
  logic [LEVEL_W-1:0]       lshare;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic                     wr_en;
  logic                     addr_ok;
  logic                     rd_en;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic [SAMPLE_W-1:0]      rd_data;

  // handshake and item decode
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign is_tick   = (in_data.command == CMD_TICK);
  assign muted     = (cfg.volume <= cfg.silence_level);
  assign mute_fire = in_fire && is_tick && muted;
  assign step_fire = in_fire && is_tick && !muted;
  assign load_out  = (state_r == ST_DONE) && out_free;

  // clamped operands
  assign len    = (32'(cfg.table_length) > 32'(TABLE_DEPTH)) ? LEN_CLAMP : cfg.table_length;
  assign gain   = (cfg.volume > UNITY) ? UNITY : cfg.volume;
  assign rshare = (cfg.pan > UNITY) ? UNITY : cfg.pan;
  assign lshare = UNITY - rshare;

  // table port addressing
  assign addr_ok = (32'(in_data.table_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(in_data.table_index);
  assign rd_addr = AW'(mul_p[IDX_HI:IDX_LO]);

  // next state and multiplier operand select
  always_comb begin
    state_nxt = state_r;
    mul_a     = sg_r;
    mul_b     = {1'b0, rshare};
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_tick) begin
            wr_en = addr_ok;
          end else if (!muted) begin
            state_nxt = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        mul_a     = {1'b0, phase_r};
        mul_b     = {{(MUL_B_W-LEN_W){1'b0}}, len};
        state_nxt = ST_READ;
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        mul_a     = {{(MUL_A_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
        mul_b     = {1'b0, gain};
        state_nxt = ST_LEFT;
      end
      ST_LEFT: begin
        mul_a     = mul_p[MUL_A_W-1:0];
        mul_b     = {1'b0, lshare};
        state_nxt = ST_RIGHT;
      end
      ST_RIGHT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // phase accumulator, wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (step_fire) begin
      phase_r <= phase_r + cfg.phase_step;
    end
  end

  // scaled sample and left result holding
  always_ff @(posedge clk) begin
    if (state_r == ST_LEFT) begin
      sg_r <= mul_p[SG_W-1:0];
    end
    if (state_r == ST_RIGHT) begin
      left_r <= round_q15(mul_p);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out || mute_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.left_sample  <= left_r;
      out_data_r.right_sample <= round_q15(mul_p);
    end else if (mute_fire) begin
      out_data_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wvp_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  wvp_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.table_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // a sounding tick starts the index multiply
  `ASSERT_NEXT(a_tick_starts, step_fire, state_r == ST_INDEX, "tick did not start sequence")
  // a muted tick leaves the phase alone
  `ASSERT_NEXT(a_mute_phase, mute_fire, $stable(phase_r), "muted tick moved phase")
  // a table write alone never makes a result
  `ASSERT_NEXT(a_write_quiet, in_fire && !is_tick && !out_valid_r, !out_valid_r, "write made a result")
  // a result appears only from the final step or a muted tick
  `ASSERT_ALWAYS(a_out_source, $rose(out_valid_r) |-> $past(load_out || mute_fire), "stray result")

endmodule

`default_nettype wire

/* rtl/core/wavetable_voice_with_pan.sv */
// Wavetable voice with stereo pan: one oscillator voice read from a loadable table.
// Input channel (in_valid/in_ready/in_data): a tick item advances the 32-bit phase by
// phase_step, reads the table at floor(phase * table_length / 2^32), scales the entry
// by volume and splits it into a left and a right sample; a write item stores one
// table entry and gives no result. A tick while volume <= silence_level gives zeros
// and leaves the phase alone.
// Pacing: a sounding tick is worked through by the single shared multiplier (index, gain,
// left share, right share) and the table read port, and no further item is taken until
// its result is registered; the next item can be taken in the cycle after that. A write
// or a muted tick is handled in the idle state without leaving it.
// Result channel (out_valid/out_ready/out_data): one registered output slot. While a
// result waits, a further table write or tick is taken only once the slot frees.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only
// while the voice is idle. Indices beyond the register list are dropped.
// Reset (rst_n low, synchronous): phase is zero, registers take their defaults, the
// output slot is empty; the table is not cleared and must be written before it is read.
`default_nettype none

module wavetable_voice_with_pan #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire wvp_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wvp_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wvp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wvp_pkg::*;

  cfg_regs_t cfg_r;
  logic      cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= RST_PHASE_STEP;
      cfg_r.table_length  <= RST_TABLE_LENGTH;
      cfg_r.volume        <= RST_VOLUME;
      cfg_r.pan           <= RST_PAN;
      cfg_r.silence_level <= RST_SILENCE;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_PHASE_STEP:   cfg_r.phase_step    <= cfg_data[PHASE_W-1:0];
        CFG_TABLE_LENGTH: cfg_r.table_length  <= cfg_data[LEN_W-1:0];
        CFG_VOLUME:       cfg_r.volume        <= cfg_data[LEVEL_W-1:0];
        CFG_PAN:          cfg_r.pan           <= cfg_data[LEVEL_W-1:0];
        CFG_SILENCE:      cfg_r.silence_level <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wvp_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/wvp_voice_scoreboard_pkg.sv */
// stereo sample predictor and result checker for the wavetable voice testbench
package wvp_voice_scoreboard_pkg;
  import wvp_pkg::*;

  localparam int WAVE_ENTRIES = 4096;
  localparam int REPORT_LIMIT = 10;

  class voice_scoreboard;
    // voice registers as the block holds them
    logic [PHASE_W-1:0] step_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [LEVEL_W-1:0] gain_reg;
    logic [LEVEL_W-1:0] pan_reg;
    logic [LEVEL_W-1:0] mute_reg;

    // oscillator state and the table contents seen so far
    logic [PHASE_W-1:0]         phase_now;
    logic signed [SAMPLE_W-1:0] wave_mem [WAVE_ENTRIES];
    bit                         wave_loaded [WAVE_ENTRIES];

    out_item_t expected_samples[$];

    int unsigned faults;
    int unsigned n_checked;
    int unsigned n_sounding;
    int unsigned n_muted;
    int unsigned n_writes;

    function new();
      step_reg   = RST_PHASE_STEP;
      length_reg = RST_TABLE_LENGTH;
      gain_reg   = RST_VOLUME;
      pan_reg    = RST_PAN;
      mute_reg   = RST_SILENCE;
      phase_now  = '0;
      foreach (wave_loaded[i]) wave_loaded[i] = 1'b0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PHASE_STEP:   step_reg   = data[PHASE_W-1:0];
        CFG_TABLE_LENGTH: length_reg = data[LEN_W-1:0];
        CFG_VOLUME:       gain_reg   = data[LEVEL_W-1:0];
        CFG_PAN:          pan_reg    = data[LEVEL_W-1:0];
        CFG_SILENCE:      mute_reg   = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // entry read at a given phase, table length clamped to the table size
    function logic [WIDX_W-1:0] entry_at(logic [PHASE_W-1:0] ph);
      logic [63:0]      span;
      logic [63:0]      pos;
      span = (length_reg > LEN_W'(WAVE_ENTRIES)) ? 64'(WAVE_ENTRIES) : 64'(length_reg);
      pos = (64'(ph) * span) >> PHASE_W;
      return pos[WIDX_W-1:0];
    endfunction

    function logic [WIDX_W-1:0] next_tick_entry();
      return entry_at(phase_now + step_reg);
    endfunction

    // true when the next tick is muted or reads a loaded entry
    function bit next_tick_is_safe();
      return (gain_reg <= mute_reg) || wave_loaded[next_tick_entry()];
    endfunction

    // sample * gain * share, rounded half up to q1.15
    function logic signed [SAMPLE_W-1:0] scaled_share(logic signed [SAMPLE_W-1:0] s,
                                                      logic [LEVEL_W-1:0] gain,
                                                      logic [LEVEL_W-1:0] share);
      longint sv;
      longint gv;
      longint hv;
      longint prod;
      sv = s;
      gv = gain;
      hv = share;
      prod = sv * gv * hv;
      prod = (prod + (longint'(1) <<< 29)) >>> 30;
      return prod[SAMPLE_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t                  res;
      logic signed [SAMPLE_W-1:0] s;
      logic [LEVEL_W-1:0]         gain;
      logic [LEVEL_W-1:0]         right_share;
      if (it.command == CMD_WRITE) begin
        wave_mem[it.table_index]    = it.table_value;
        wave_loaded[it.table_index] = 1'b1;
        n_writes++;
        return;
      end
      // muted tick gives silence and holds the phase
      if (gain_reg <= mute_reg) begin
        res = '0;
        n_muted++;
      end else begin
        phase_now = phase_now + step_reg;
        s = wave_mem[entry_at(phase_now)];
        gain = (gain_reg > UNITY) ? UNITY : gain_reg;
        right_share = (pan_reg > UNITY) ? UNITY : pan_reg;
        res.left_sample  = scaled_share(s, gain, UNITY - right_share);
        res.right_sample = scaled_share(s, gain, right_share);
        n_sounding++;
      end
      expected_samples.push_back(res);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (expected_samples.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: unexpected stereo result L=%0d R=%0d", $time,
                   got.left_sample, got.right_sample);
        return;
      end
      want = expected_samples.pop_front();
      n_checked++;
      if (got.left_sample !== want.left_sample || got.right_sample !== want.right_sample) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: stereo mismatch expected L=%0d R=%0d got L=%0d R=%0d", $time,
                   want.left_sample, want.right_sample, got.left_sample, got.right_sample);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

/* verif/tb_wavetable_voice_with_pan.sv */
// testbench top for the wavetable voice with pan: stimulus, handshakes and final verdict
module tb_wavetable_voice_with_pan;
  import wvp_pkg::*;
  import wvp_voice_scoreboard_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int SEGMENTS      = 9;
  localparam int SEGMENT_ITEMS = 172;
  localparam int RUN_LIMIT     = 4_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  voice_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned n_settings = 0;

  wavetable_voice_with_pan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every result transfer goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // sender idles until nothing is expected, then lets the block settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    // occasional full stop of the sender mid-stream
    if (send_idle_pct != 0 && $urandom_range(99) == 0) wait_for_results();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_write(input logic [WIDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    in_item_t it;
    it.command     = CMD_WRITE;
    it.table_index = idx;
    it.table_value = val;
    send_item(it);
  endtask

  // a tick, preceded by a load of the entry it reads when that entry is still empty
  task automatic send_tick();
    in_item_t it;
    if (!sb.next_tick_is_safe()) send_write(sb.next_tick_entry(), SAMPLE_W'($urandom));
    it.command     = CMD_TICK;
    it.table_index = WIDX_W'($urandom);
    it.table_value = SAMPLE_W'($urandom);
    send_item(it);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  // registers change only with the voice idle; unused upper data bits carry noise
  task automatic program_voice(input logic [PHASE_W-1:0] step, input logic [LEN_W-1:0] len,
                               input logic [LEVEL_W-1:0] vol, input logic [LEVEL_W-1:0] pan,
                               input logic [LEVEL_W-1:0] sil);
    wait_for_results();
    cfg_write(CFG_PHASE_STEP, step);
    cfg_write(CFG_TABLE_LENGTH, {19'($urandom), len});
    cfg_write(CFG_VOLUME, {16'($urandom), vol});
    cfg_write(CFG_PAN, {16'($urandom), pan});
    cfg_write(CFG_SILENCE, {16'($urandom), sil});
    cfg_write(CFG_UNMAPPED, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic program_random_voice();
    logic [PHASE_W-1:0] step;
    logic [LEN_W-1:0]   len;
    logic [LEVEL_W-1:0] vol;
    logic [LEVEL_W-1:0] pan;
    logic [LEVEL_W-1:0] sil;
    case ($urandom_range(4))
      0: step = $urandom;
      1: step = $urandom >> $urandom_range(6, 24);
      2: step = 32'hFFFF_FFFF - $urandom_range(4096);
      3: step = 32'h8000_0000;
      default: step = PHASE_W'($urandom_range(3));
    endcase
    case ($urandom_range(4))
      0: len = 13'd1;
      1: len = 13'd4096;
      2: len = LEN_W'($urandom_range(2, 64));
      3: len = LEN_W'($urandom_range(1, 4096));
      default: len = $urandom_range(1) ? 13'd0 : LEN_W'($urandom_range(4097, 8191));
    endcase
    case ($urandom_range(2))
      0: vol = UNITY;
      1: vol = LEVEL_W'($urandom_range(1, 32768));
      default: vol = LEVEL_W'($urandom_range(32769, 65535));
    endcase
    case ($urandom_range(3))
      0: pan = 16'd0;
      1: pan = UNITY;
      2: pan = LEVEL_W'($urandom_range(32768));
      default: pan = LEVEL_W'($urandom);
    endcase
    // mostly audible, sometimes muted at or above the volume
    case ($urandom_range(5))
      0: sil = 16'd0;
      1: sil = RST_SILENCE;
      2: sil = LEVEL_W'($urandom_range(vol));
      3: sil = 16'hFFFF;
      default: sil = LEVEL_W'($urandom_range(vol - 1));
    endcase
    program_voice(step, len, vol, pan, sil);
  endtask

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("wavetable_voice_with_pan regression: fail");
    $finish;
  end

  initial begin
    int unsigned seg_goal;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sample extremes at reset settings
    send_write(12'h000, 16'h8000);
    send_tick();
    send_write(12'h000, 16'h7FFF);
    send_tick();
    send_write(12'h000, 16'h0000);
    send_tick();
    send_write(12'h000, 16'hFFFF);
    send_tick();

    // last entry, oversized table length, gain and pan above one
    program_voice(32'hFFFF_FFFF, 13'd8191, 16'hFFFF, 16'hFFFF, 16'd0);
    send_write(12'hFFF, 16'h7FFF);
    send_tick();
    send_write(12'hFFF, 16'h8000);
    send_tick();

    // zero table length reads entry zero; tiny gain, all left
    program_voice(32'h0123_4567, 13'd0, 16'd1, 16'd0, 16'd0);
    send_write(12'hAAA, 16'h5555);
    send_write(12'h555, 16'hAAAA);
    send_tick();
    send_tick();

    // muted at equality, then muted with zero volume
    program_voice(32'h4000_0000, 13'd1, UNITY, UNITY, UNITY);
    send_tick();
    program_voice(32'h4000_0000, 13'd16, 16'd0, 16'd16384, 16'd0);
    send_tick();

    // audible again on a short table
    program_voice(32'h1000_0000, 13'd16, UNITY, 16'd16384, RST_SILENCE);
    send_tick();
    send_tick();
    send_tick();

    // random part: idling mode changes every third segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_random_voice();
      seg_goal = items_sent + SEGMENT_ITEMS;
      while (items_sent < seg_goal) begin
        if ($urandom_range(99) < 20) send_write(WIDX_W'($urandom), SAMPLE_W'($urandom));
        else send_tick();
      end
    end

    wait_for_results();
    $display("covered %0d sounding ticks, %0d muted ticks, %0d table writes over %0d settings",
             sb.n_sounding, sb.n_muted, sb.n_writes, n_settings);
    $display("checked %0d stereo results, %0d failures, %0d still expected",
             sb.n_checked, sb.faults, sb.pending());
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("wavetable_voice_with_pan regression: pass");
    end else begin
      $display("wavetable_voice_with_pan regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wvp_pkg.sv
rtl/core/wvp_mul.sv
rtl/core/wvp_table.sv
rtl/core/wvp_seq.sv
rtl/core/wavetable_voice_with_pan.sv
verif/wvp_voice_scoreboard_pkg.sv
verif/tb_wavetable_voice_with_pan.sv
